FILE: hdl/lcdt_pkg.sv
// Shared types, constants and helper functions for the LCD mode timing controller.
// No dependencies; used by lcdt_advance and lcd_mode_timing_controller_core.
package lcdt_pkg;

  localparam int unsigned VISIBLE_LINES_DEF = 144;
  localparam int unsigned MAX_SPRITES_DEF   = 10;

  localparam int unsigned LenW = 17;

  // Phase lengths in clocks
  localparam logic [LenW-1:0] LEN_OAM       = 17'd80;
  localparam logic [LenW-1:0] LEN_XFER      = 17'd172;
  localparam logic [LenW-1:0] LEN_HBL       = 17'd200;
  localparam logic [LenW-1:0] LEN_INC       = 17'd4;
  localparam logic [LenW-1:0] LEN_VBL_LINE  = 17'd452;
  localparam logic [LenW-1:0] LEN_OFF_FRAME = 17'd70224;

  localparam logic [7:0] LAST_LINE = 8'd153;

  // LCDC / STAT bit positions
  localparam int unsigned LCDC_ON     = 7;
  localparam int unsigned STAT_LYC_EN = 6;
  localparam int unsigned STAT_OAM_EN = 5;
  localparam int unsigned STAT_VBL_EN = 4;
  localparam int unsigned STAT_HBL_EN = 3;
  localparam int unsigned STAT_COIN   = 2;

  localparam logic [7:0] STAT_WR_MASK   = 8'h78;
  localparam logic [7:0] STAT_KEEP_MASK = 8'h07;

  // STAT mode codes
  localparam logic [1:0] MODE_HBL  = 2'd0;
  localparam logic [1:0] MODE_VBL  = 2'd1;
  localparam logic [1:0] MODE_OAM  = 2'd2;
  localparam logic [1:0] MODE_XFER = 2'd3;

  typedef enum logic [1:0] {
    FN_TICK = 2'd0,
    FN_LCDC = 2'd1,
    FN_STAT = 2'd2,
    FN_LYC  = 2'd3
  } lcdt_func_e;

  typedef enum logic [2:0] {
    PH_OAM     = 3'd0,
    PH_XFER    = 3'd1,
    PH_HBL     = 3'd2,
    PH_HBL_INC = 3'd3,
    PH_VBL     = 3'd4,
    PH_VBL_INC = 3'd5,
    PH_L153    = 3'd6,
    PH_END     = 3'd7
  } lcdt_phase_e;

  // Architectural state of the sequencer, less the clock accumulator
  typedef struct packed {
    logic [7:0]      lcdc;
    logic [7:0]      stat;
    logic [7:0]      lyc;
    logic [7:0]      ly;
    lcdt_phase_e     phase;
    logic [LenW-1:0] plen;
    logic [3:0]      slatch;
    logic            taken;
  } lcdt_regs_t;

  // Interrupt and frame events raised by one phase step
  typedef struct packed {
    logic lcdc_irq;
    logic vbl_irq;
    logic frame;
  } lcdt_evt_t;

  // Transfer-phase extension per sprite count; counts above ten saturate
  function automatic logic [6:0] penalty(input logic [3:0] n);
    logic [6:0] p;
    case (n)
      4'd0:    p = 7'd0;
      4'd1:    p = 7'd8;
      4'd2:    p = 7'd20;
      4'd3:    p = 7'd32;
      4'd4:    p = 7'd44;
      4'd5:    p = 7'd52;
      4'd6:    p = 7'd64;
      4'd7:    p = 7'd76;
      4'd8:    p = 7'd88;
      4'd9:    p = 7'd96;
      default: p = 7'd108;
    endcase
    return p;
  endfunction

  // LY == LYC check; hit reports a one-shot LCDC request
  function automatic lcdt_regs_t coincide(input lcdt_regs_t r, output logic hit);
    lcdt_regs_t o;
    o   = r;
    hit = 1'b0;
    if (o.lyc == o.ly) begin
      o.stat[STAT_COIN] = 1'b1;
      if (o.stat[STAT_LYC_EN] && !o.taken) begin
        hit     = 1'b1;
        o.taken = 1'b1;
      end
    end else begin
      o.stat[STAT_COIN] = 1'b0;
    end
    return o;
  endfunction

endpackage

FILE: hdl/lcd_mode_timing_controller_core.sv
// Top level of the LCD line/mode timing controller: handshake, sequencer, output stage.
// Depends on lcdt_pkg and lcdt_advance.

// Each input beat is a tick of clock_delta clocks or a write to LCDC, STAT or
// LYC, and each produces exactly one result beat with STAT, LY, the interrupt
// and frame pulses raised during that beat, and the VRAM/OAM access gates.
// A register write passes from IDLE to DONE and is loaded into the result
// register there once the output stage is free. A tick adds clock_delta to
// the clock accumulator on acceptance, then the shared 17-bit
// compare/subtract unit retires one phase boundary per cycle until the
// accumulator falls below the current phase length. A tick crosses 0 to 4
// phase boundaries with the display on (when a full-penalty transfer, a short
// hblank, the line increment and OAM scan all end inside one tick of the largest clock_delta)
// and at most 1 with it off; its result is loaded from DONE like a write's.
// in_stall_o is high while a beat is being worked on; a finished result sits
// in the output register and does not hold off the next input beat, though
// the next result waits until that one is taken. The sprite count rides
// with every tick and is latched when the transfer phase starts; counts
// above MAX_SPRITES saturate. After reset the display is off and the first
// tick completes a frame at once.
module lcd_mode_timing_controller_core #(
  parameter int unsigned VISIBLE_LINES = lcdt_pkg::VISIBLE_LINES_DEF,
  parameter int unsigned MAX_SPRITES   = lcdt_pkg::MAX_SPRITES_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,

  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] func_i,
  input  logic [7:0] clock_delta_i,
  input  logic [3:0] sprite_count_i,
  input  logic [7:0] write_data_i,

  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] stat_value_o,
  output logic [7:0] line_number_o,
  output logic       lcdc_irq_o,
  output logic       vblank_irq_o,
  output logic       frame_ready_o,
  output logic       vram_open_o,
  output logic       oam_open_o
);

  localparam logic [3:0] SprMax = 4'(MAX_SPRITES);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOP,
    ST_DONE
  } state_e;

  state_e                      state_q, state_d;
  lcdt_pkg::lcdt_regs_t        regs_q, regs_d;
  logic [lcdt_pkg::LenW-1:0]   accum_q, accum_d;
  lcdt_pkg::lcdt_evt_t         evt_q, evt_d;
  logic [3:0]                  spr_q, spr_d;

  logic                        out_valid_q, out_valid_d;
  logic [7:0]                  stat_q, stat_d;
  logic [7:0]                  ly_q, ly_d;
  lcdt_pkg::lcdt_evt_t         oevt_q, oevt_d;
  logic                        vram_q, vram_d;
  logic                        oam_q, oam_d;

  lcdt_pkg::lcdt_regs_t        adv_regs;
  lcdt_pkg::lcdt_evt_t         adv_evt;

  logic [lcdt_pkg::LenW:0]     diff;
  logic [3:0]                  spr_sat;
  logic                        out_free;

  lcdt_advance #(
    .VISIBLE_LINES(VISIBLE_LINES)
  ) u_advance (
    .cur_i    (regs_q),
    .sprites_i(spr_q),
    .nxt_o    (adv_regs),
    .evt_o    (adv_evt)
  );

  // shared compare/subtract: borrow out means accumulator < phase length
  assign diff     = {1'b0, accum_q} - {1'b0, regs_q.plen};
  assign spr_sat  = (sprite_count_i > SprMax) ? SprMax : sprite_count_i;
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    lcdt_pkg::lcdt_regs_t w;
    logic                 hit;
    w           = regs_q;
    hit         = 1'b0;
    state_d     = state_q;
    regs_d      = regs_q;
    accum_d     = accum_q;
    evt_d       = evt_q;
    spr_d       = spr_q;
    out_valid_d = out_valid_q && out_stall_i;
    stat_d      = stat_q;
    ly_d        = ly_q;
    oevt_d      = oevt_q;
    vram_d      = vram_q;
    oam_d       = oam_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          evt_d   = '0;
          spr_d   = spr_sat;
          state_d = ST_DONE;
          unique case (lcdt_pkg::lcdt_func_e'(func_i))
            lcdt_pkg::FN_TICK: begin
              accum_d = accum_q + 17'(clock_delta_i);
              state_d = ST_LOOP;
            end
            lcdt_pkg::FN_LCDC: begin
              if (!write_data_i[lcdt_pkg::LCDC_ON]) begin
                w.stat[1:0] = lcdt_pkg::MODE_HBL;
                w.ly        = '0;
              end else if (!regs_q.lcdc[lcdt_pkg::LCDC_ON]) begin
                // switch-on: restart at the transfer phase boundary
                w.slatch = '0;
                accum_d  = '0;
                w.taken  = 1'b0;
                w.ly     = '0;
                w = lcdt_pkg::coincide(w, hit);
                w.stat[1:0] = lcdt_pkg::MODE_HBL;
                w.phase     = lcdt_pkg::PH_XFER;
                w.plen      = lcdt_pkg::LEN_OAM;
              end
              w.lcdc = write_data_i;
            end
            lcdt_pkg::FN_STAT: begin
              w.stat = (regs_q.stat & lcdt_pkg::STAT_KEEP_MASK) |
                       (write_data_i & lcdt_pkg::STAT_WR_MASK);
              // STAT-write quirk: spurious request in hblank or vblank
              hit = regs_q.lcdc[lcdt_pkg::LCDC_ON] &&
                    (regs_q.stat[1:0] == lcdt_pkg::MODE_HBL ||
                     regs_q.stat[1:0] == lcdt_pkg::MODE_VBL);
            end
            lcdt_pkg::FN_LYC: begin
              if (regs_q.lyc != write_data_i) begin
                w.lyc = write_data_i;
                if (regs_q.phase != lcdt_pkg::PH_HBL_INC &&
                    regs_q.phase != lcdt_pkg::PH_VBL_INC) begin
                  w = lcdt_pkg::coincide(w, hit);
                end
              end
            end
            default: ;
          endcase
          regs_d         = w;
          evt_d.lcdc_irq = hit;
        end
      end
      ST_LOOP: begin
        if (!diff[lcdt_pkg::LenW]) begin
          accum_d = diff[lcdt_pkg::LenW-1:0];
          regs_d  = adv_regs;
          evt_d   = evt_q | adv_evt;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          stat_d      = regs_q.stat;
          ly_d        = regs_q.ly;
          oevt_d      = evt_q;
          vram_d      = (regs_q.stat[1:0] != lcdt_pkg::MODE_XFER) ||
                        !regs_q.lcdc[lcdt_pkg::LCDC_ON];
          oam_d       = (regs_q.stat[1:0] == lcdt_pkg::MODE_HBL) ||
                        (regs_q.stat[1:0] == lcdt_pkg::MODE_VBL) ||
                        !regs_q.lcdc[lcdt_pkg::LCDC_ON];
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      regs_q      <= '{phase: lcdt_pkg::PH_OAM, default: '0};
      accum_q     <= '0;
      evt_q       <= '0;
      spr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      regs_q      <= regs_d;
      accum_q     <= accum_d;
      evt_q       <= evt_d;
      spr_q       <= spr_d;
      out_valid_q <= out_valid_d;
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk_i) begin
    stat_q <= stat_d;
    ly_q   <= ly_d;
    oevt_q <= oevt_d;
    vram_q <= vram_d;
    oam_q  <= oam_d;
  end

  assign in_stall_o    = (state_q != ST_IDLE);
  assign out_valid_o   = out_valid_q;
  assign stat_value_o  = stat_q;
  assign line_number_o = ly_q;
  assign lcdc_irq_o    = oevt_q.lcdc_irq;
  assign vblank_irq_o  = oevt_q.vbl_irq;
  assign frame_ready_o = oevt_q.frame;
  assign vram_open_o   = vram_q;
  assign oam_open_o    = oam_q;

  // between beats the accumulator never reaches a nonzero phase length
  a_accum_below_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE && regs_q.plen != '0) |-> (accum_q < regs_q.plen))
    else $error("clock accumulator not below phase length while idle");

  // STAT bit 7 is never writable
  a_stat_msb_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !regs_q.stat[7])
    else $error("STAT bit 7 set");

  // a result is only loaded when the output stage is free
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && out_valid_q && out_stall_i) |=> (state_q == ST_DONE))
    else $error("result left DONE while output stage was held");

  // an accepted beat always takes the sequencer out of idle
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (state_q != ST_IDLE))
    else $error("sequencer idle right after accepting a beat");

endmodule

FILE: hdl/lcdt_advance.sv
// One phase step of the LCD line/mode sequencer (combinational).
// Depends on lcdt_pkg.
module lcdt_advance #(
  parameter int unsigned VISIBLE_LINES = lcdt_pkg::VISIBLE_LINES_DEF
) (
  input  lcdt_pkg::lcdt_regs_t cur_i,
  input  logic [3:0]           sprites_i,
  output lcdt_pkg::lcdt_regs_t nxt_o,
  output lcdt_pkg::lcdt_evt_t  evt_o
);

  localparam logic [7:0] VisLine = 8'(VISIBLE_LINES);

  lcdt_pkg::lcdt_regs_t r;
  lcdt_pkg::lcdt_evt_t  e;
  logic [6:0]           pen;
  logic                 hit;

  always_comb begin
    r   = cur_i;
    e   = '0;
    pen = '0;
    hit = 1'b0;
    if (!r.lcdc[lcdt_pkg::LCDC_ON]) begin
      // display off: free-running frame timer
      r.ly    = '0;
      r.plen  = lcdt_pkg::LEN_OFF_FRAME;
      e.frame = 1'b1;
    end else begin
      if (r.phase == lcdt_pkg::PH_XFER) r.slatch = sprites_i;
      pen = lcdt_pkg::penalty(r.slatch);
      unique case (r.phase)
        lcdt_pkg::PH_OAM: begin
          r.stat[1:0] = lcdt_pkg::MODE_OAM;
          if (r.stat[lcdt_pkg::STAT_OAM_EN] && !r.taken) begin
            e.lcdc_irq = 1'b1;
            r.taken    = 1'b1;
          end
          r = lcdt_pkg::coincide(r, hit);
          e.lcdc_irq = e.lcdc_irq | hit;
          r.phase = lcdt_pkg::PH_XFER;
          r.plen  = lcdt_pkg::LEN_OAM;
        end
        lcdt_pkg::PH_XFER: begin
          r.stat[1:0] = lcdt_pkg::MODE_XFER;
          r.phase     = lcdt_pkg::PH_HBL;
          r.plen      = lcdt_pkg::LEN_XFER + 17'(pen);
        end
        lcdt_pkg::PH_HBL: begin
          r.stat[1:0] = lcdt_pkg::MODE_HBL;
          if (r.stat[lcdt_pkg::STAT_HBL_EN] && !r.taken) begin
            e.lcdc_irq = 1'b1;
            r.taken    = 1'b1;
          end
          r.phase = lcdt_pkg::PH_HBL_INC;
          r.plen  = lcdt_pkg::LEN_HBL - 17'(pen);
        end
        lcdt_pkg::PH_HBL_INC: begin
          r.ly = r.ly + 8'd1;
          r.stat[lcdt_pkg::STAT_COIN] = 1'b0;
          r.taken = 1'b0;
          r.phase = (r.ly == VisLine) ? lcdt_pkg::PH_VBL : lcdt_pkg::PH_OAM;
          r.plen  = lcdt_pkg::LEN_INC;
        end
        lcdt_pkg::PH_VBL: begin
          if (r.ly == VisLine) begin
            r.stat[1:0] = lcdt_pkg::MODE_VBL;
            e.vbl_irq   = 1'b1;
            // mode-1 request bypasses the one-shot latch
            if (r.stat[lcdt_pkg::STAT_VBL_EN]) e.lcdc_irq = 1'b1;
          end
          r = lcdt_pkg::coincide(r, hit);
          e.lcdc_irq = e.lcdc_irq | hit;
          r.phase = lcdt_pkg::PH_VBL_INC;
          r.plen  = lcdt_pkg::LEN_VBL_LINE;
        end
        lcdt_pkg::PH_VBL_INC: begin
          r.ly = r.ly + 8'd1;
          r.stat[lcdt_pkg::STAT_COIN] = 1'b0;
          r.phase = (r.ly == lcdt_pkg::LAST_LINE) ? lcdt_pkg::PH_L153 : lcdt_pkg::PH_VBL;
          r.taken = 1'b0;
          r.plen  = lcdt_pkg::LEN_INC;
        end
        lcdt_pkg::PH_L153: begin
          r = lcdt_pkg::coincide(r, hit);
          e.lcdc_irq = e.lcdc_irq | hit;
          r.ly    = '0;
          r.phase = lcdt_pkg::PH_END;
          r.plen  = lcdt_pkg::LEN_VBL_LINE;
        end
        lcdt_pkg::PH_END: begin
          r.stat[1:0] = lcdt_pkg::MODE_HBL;
          r.taken = 1'b0;
          e.frame = 1'b1;
          r.phase = lcdt_pkg::PH_OAM;
          r.plen  = lcdt_pkg::LEN_INC;
        end
        default: ;
      endcase
    end
  end

  assign nxt_o = r;
  assign evt_o = e;

endmodule

FILE: sim/lcd_timing_checker.sv
`timescale 1ns / 100ps
// Checker for the LCD mode timing controller: watches the input and result channels,
// predicts each result beat from its own line/mode sequencer and compares all fields.
// Depends on lcdt_pkg for the function codes, phase names, bit positions and lengths.
module lcd_timing_checker
  import lcdt_pkg::*;
#(
  parameter int unsigned VISIBLE_LINES = VISIBLE_LINES_DEF,
  parameter int unsigned MAX_SPRITES   = MAX_SPRITES_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_stall_i,
  input  logic [1:0] func_i,
  input  logic [7:0] clock_delta_i,
  input  logic [3:0] sprite_count_i,
  input  logic [7:0] write_data_i,
  input  logic       out_valid_i,
  input  logic       out_stall_i,
  input  logic [7:0] stat_value_i,
  input  logic [7:0] line_number_i,
  input  logic       lcdc_irq_i,
  input  logic       vblank_irq_i,
  input  logic       frame_ready_i,
  input  logic       vram_open_i,
  input  logic       oam_open_i,
  output int         fail_count_o,
  output int         pending_o
);

  localparam logic [7:0] VBLANK_LY = 8'(VISIBLE_LINES % 256);

  typedef struct packed {
    logic [7:0] stat;
    logic [7:0] ly;
    logic       lcdc_irq;
    logic       vbl_irq;
    logic       frame;
    logic       vram;
    logic       oam;
  } lcd_result_t;

  // sequencer state
  logic [7:0]  lcdc_q, stat_q, lyc_q, ly_q;
  lcdt_phase_e phase_q;
  int unsigned accum_q, plen_q, slatch_q;
  logic        taken_q;
  logic        lcdc_pulse, vbl_pulse, frame_pulse;

  lcd_result_t expected_status_q[$];
  lcd_result_t want, got;
  int          mismatches;
  int          beat_no;

  function automatic int unsigned xfer_penalty(int unsigned n);
    case (n)
      0:       return 0;
      1:       return 8;
      2:       return 20;
      3:       return 32;
      4:       return 44;
      5:       return 52;
      6:       return 64;
      7:       return 76;
      8:       return 88;
      9:       return 96;
      default: return 108;
    endcase
  endfunction

  // append one predicted beat at the tail of the expected list
  function automatic void stash_expected(lcd_result_t r);
    expected_status_q = {expected_status_q, r};
  endfunction

  function automatic void check_coincidence();
    if (lyc_q == ly_q) begin
      stat_q[STAT_COIN] = 1'b1;
      if (stat_q[STAT_LYC_EN] && !taken_q) begin
        lcdc_pulse = 1'b1;
        taken_q    = 1'b1;
      end
    end else begin
      stat_q[STAT_COIN] = 1'b0;
    end
  endfunction

  function automatic lcd_result_t predict_beat(lcdt_func_e f, logic [7:0] delta,
                                               logic [3:0] sc, logic [7:0] wd);
    int unsigned sprites;
    int unsigned pen;
    lcd_result_t r;
    sprites = (sc > MAX_SPRITES) ? MAX_SPRITES : sc;
    if (sprites > 10) sprites = 10;
    lcdc_pulse  = 1'b0;
    vbl_pulse   = 1'b0;
    frame_pulse = 1'b0;
    case (f)
      FN_TICK: begin
        accum_q += delta;
        while (accum_q >= plen_q) begin
          accum_q -= plen_q;
          if (!lcdc_q[LCDC_ON]) begin
            ly_q        = 8'd0;
            plen_q      = LEN_OFF_FRAME;
            frame_pulse = 1'b1;
          end else begin
            if (phase_q == PH_XFER) slatch_q = sprites;
            pen = xfer_penalty(slatch_q);
            case (phase_q)
              PH_OAM: begin
                stat_q[1:0] = MODE_OAM;
                if (stat_q[STAT_OAM_EN] && !taken_q) begin
                  lcdc_pulse = 1'b1;
                  taken_q    = 1'b1;
                end
                check_coincidence();
                phase_q = PH_XFER;
                plen_q  = LEN_OAM;
              end
              PH_XFER: begin
                stat_q[1:0] = MODE_XFER;
                phase_q     = PH_HBL;
                plen_q      = LEN_XFER + pen;
              end
              PH_HBL: begin
                stat_q[1:0] = MODE_HBL;
                if (stat_q[STAT_HBL_EN] && !taken_q) begin
                  lcdc_pulse = 1'b1;
                  taken_q    = 1'b1;
                end
                phase_q = PH_HBL_INC;
                plen_q  = LEN_HBL - pen;
              end
              PH_HBL_INC: begin
                ly_q              = ly_q + 8'd1;
                stat_q[STAT_COIN] = 1'b0;
                taken_q           = 1'b0;
                if (ly_q == VBLANK_LY) phase_q = PH_VBL;
                else phase_q = PH_OAM;
                plen_q = LEN_INC;
              end
              PH_VBL: begin
                if (ly_q == VBLANK_LY) begin
                  stat_q[1:0] = MODE_VBL;
                  vbl_pulse   = 1'b1;
                  // vblank-entry request bypasses the one-shot latch
                  if (stat_q[STAT_VBL_EN]) lcdc_pulse = 1'b1;
                end
                check_coincidence();
                phase_q = PH_VBL_INC;
                plen_q  = LEN_VBL_LINE;
              end
              PH_VBL_INC: begin
                ly_q              = ly_q + 8'd1;
                stat_q[STAT_COIN] = 1'b0;
                if (ly_q == LAST_LINE) phase_q = PH_L153;
                else phase_q = PH_VBL;
                taken_q = 1'b0;
                plen_q  = LEN_INC;
              end
              PH_L153: begin
                check_coincidence();
                ly_q    = 8'd0;
                phase_q = PH_END;
                plen_q  = LEN_VBL_LINE;
              end
              default: begin
                stat_q[1:0] = MODE_HBL;
                taken_q     = 1'b0;
                frame_pulse = 1'b1;
                phase_q     = PH_OAM;
                plen_q      = LEN_INC;
              end
            endcase
          end
        end
      end
      FN_LCDC: begin
        if (!wd[LCDC_ON]) begin
          stat_q[1:0] = MODE_HBL;
          ly_q        = 8'd0;
        end else if (!lcdc_q[LCDC_ON]) begin
          slatch_q = 0;
          accum_q  = 0;
          taken_q  = 1'b0;
          ly_q     = 8'd0;
          check_coincidence();
          stat_q[1:0] = MODE_HBL;
          phase_q     = PH_XFER;
          plen_q      = LEN_OAM;
        end
        lcdc_q = wd;
      end
      FN_STAT: begin
        stat_q = (stat_q & STAT_KEEP_MASK) | (wd & STAT_WR_MASK);
        // write during hblank/vblank with display on fires a spurious request
        if (lcdc_q[LCDC_ON] && (stat_q[1:0] == MODE_HBL || stat_q[1:0] == MODE_VBL))
          lcdc_pulse = 1'b1;
      end
      default: begin
        if (lyc_q != wd) begin
          lyc_q = wd;
          if (phase_q != PH_HBL_INC && phase_q != PH_VBL_INC) check_coincidence();
        end
      end
    endcase
    r.stat     = stat_q;
    r.ly       = ly_q;
    r.lcdc_irq = lcdc_pulse;
    r.vbl_irq  = vbl_pulse;
    r.frame    = frame_pulse;
    r.vram     = (stat_q[1:0] != MODE_XFER) || !lcdc_q[LCDC_ON];
    r.oam      = (stat_q[1:0] == MODE_HBL) || (stat_q[1:0] == MODE_VBL) || !lcdc_q[LCDC_ON];
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lcdc_q   = 8'd0;
      stat_q   = 8'd0;
      lyc_q    = 8'd0;
      ly_q     = 8'd0;
      phase_q  = PH_OAM;
      accum_q  = 0;
      plen_q   = 0;
      slatch_q = 0;
      taken_q  = 1'b0;
      expected_status_q.delete();
      mismatches = 0;
      beat_no    = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (in_valid_i && !in_stall_i)
        stash_expected(predict_beat(lcdt_func_e'(func_i), clock_delta_i,
                                    sprite_count_i, write_data_i));
      if (out_valid_i && !out_stall_i) begin
        got = {stat_value_i, line_number_i, lcdc_irq_i, vblank_irq_i, frame_ready_i,
               vram_open_i, oam_open_i};
        if (expected_status_q.size() == 0) begin
          if (mismatches < 10)
            $display("result beat %0d arrived with nothing pending: stat %h ly %0d",
                     beat_no, got.stat, got.ly);
          mismatches++;
        end else begin
          want = expected_status_q.pop_front();
          if (got !== want) begin
            if (mismatches < 10)
              $display({"result beat %0d differs: exp stat %h ly %0d lcdc %b vbl %b ",
                        "frame %b vram %b oam %b, got stat %h ly %0d lcdc %b vbl %b ",
                        "frame %b vram %b oam %b"}, beat_no,
                       want.stat, want.ly, want.lcdc_irq, want.vbl_irq, want.frame,
                       want.vram, want.oam, got.stat, got.ly, got.lcdc_irq, got.vbl_irq,
                       got.frame, got.vram, got.oam);
            mismatches++;
          end
        end
        beat_no++;
      end
      fail_count_o <= mismatches;
      pending_o    <= expected_status_q.size();
    end
  end

endmodule

FILE: sim/lcd_mode_timing_controller_core_test.sv
`timescale 1ns / 100ps
// Testbench top for the LCD mode timing controller: clock, reset, stimulus and verdict.
// Depends on lcdt_pkg, lcd_mode_timing_controller_core and lcd_timing_checker.
module lcd_mode_timing_controller_core_test;
  import lcdt_pkg::*;

  localparam int RANDOM_BEATS = 1430;
  localparam int RUN_LIMIT    = 800000;  // worst case is far below this
  localparam int DRAIN_CYCLES = 100;
  localparam int HOLD_CYCLES  = 400;     // long receiver hold-off

  logic       clk_i;
  logic       rst_ni;

  // sender side
  logic       in_valid;
  lcdt_func_e func;
  logic [7:0] clock_delta;
  logic [3:0] sprite_count;
  logic [7:0] write_data;
  logic       in_stall;

  // receiver side
  logic       out_valid;
  logic       out_stall;
  logic [7:0] stat_value;
  logic [7:0] line_number;
  logic       lcdc_irq;
  logic       vblank_irq;
  logic       frame_ready;
  logic       vram_open;
  logic       oam_open;

  int         fail_count;
  int         pending;
  int         cycle_count;

  int         send_gap_pct;
  int         recv_gap_pct;
  logic       hold_off;
  logic       pressure_go;
  logic       lcd_on_sent;

  lcd_mode_timing_controller_core dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .func_i         (func),
    .clock_delta_i  (clock_delta),
    .sprite_count_i (sprite_count),
    .write_data_i   (write_data),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .stat_value_o   (stat_value),
    .line_number_o  (line_number),
    .lcdc_irq_o     (lcdc_irq),
    .vblank_irq_o   (vblank_irq),
    .frame_ready_o  (frame_ready),
    .vram_open_o    (vram_open),
    .oam_open_o     (oam_open)
  );

  lcd_timing_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_stall_i     (in_stall),
    .func_i         (func),
    .clock_delta_i  (clock_delta),
    .sprite_count_i (sprite_count),
    .write_data_i   (write_data),
    .out_valid_i    (out_valid),
    .out_stall_i    (out_stall),
    .stat_value_i   (stat_value),
    .line_number_i  (line_number),
    .lcdc_irq_i     (lcdc_irq),
    .vblank_irq_i   (vblank_irq),
    .frame_ready_i  (frame_ready),
    .vram_open_i    (vram_open),
    .oam_open_i     (oam_open),
    .fail_count_o   (fail_count),
    .pending_o      (pending)
  );

  // 12 ns clock
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Hard stop: only a hung or badly slow block gets here
  initial begin
    cycle_count = 0;
    while (cycle_count < RUN_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Mismatches found");
    $finish;
  end

  // Receiver: random stall per cycle, forced high during the hold-off window
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk_i);
      out_stall <= hold_off || ($urandom_range(99) < recv_gap_pct);
    end
  end

  // Long hold-off, counted here so the sender keeps offering beats meanwhile;
  // the block fills its result register and then stalls its input.
  initial begin
    hold_off <= 1'b0;
    wait (pressure_go === 1'b1);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    hold_off <= 1'b0;
  end

  // One beat on the input channel. Entered right after a rising edge; random
  // idle cycles first, then the beat is held until an edge with stall low.
  task automatic send_beat(input lcdt_func_e f, input logic [7:0] dl,
                           input logic [3:0] sp, input logic [7:0] wd);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid     <= 1'b1;
    func         <= f;
    clock_delta  <= dl;
    sprite_count <= sp;
    write_data   <= wd;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
  endtask

  initial begin
    lcdt_func_e rf;
    logic [7:0] rd;
    logic [7:0] rw;
    logic [3:0] rs;
    int unsigned pick;

    rst_ni       <= 1'b0;
    in_valid     <= 1'b0;
    func         <= FN_TICK;
    clock_delta  <= 8'd0;
    sprite_count <= 4'd0;
    write_data   <= 8'd0;
    pressure_go  <= 1'b0;
    send_gap_pct = 37;
    recv_gap_pct <= 84;
    lcd_on_sent  = 1'b0;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part
    send_beat(FN_TICK, 8'd0,   4'd0,  8'h00);  // display off: first tick ends a frame at once
    send_beat(FN_TICK, 8'd255, 4'd15, 8'hFF);  // max delta, sprite count out of range
    send_beat(FN_LYC,  8'd0,   4'd0,  8'h00);  // same LYC value: no effect
    send_beat(FN_LYC,  8'd0,   4'd0,  8'h05);  // new LYC with display off
    send_beat(FN_STAT, 8'd0,   4'd0,  8'hFF);  // STAT write, display off: no request
    send_beat(FN_LCDC, 8'd0,   4'd0,  8'h00);
    send_beat(FN_LCDC, 8'd0,   4'd0,  8'h80);  // switch on: LY cleared, mode reads hblank
    send_beat(FN_STAT, 8'd0,   4'd0,  8'h78);  // STAT write in hblank: spurious request
    send_beat(FN_LYC,  8'd0,   4'd0,  8'h00);  // LYC hits LY with LYC enable set
    send_beat(FN_LCDC, 8'd0,   4'd0,  8'hFF);  // already on: value only
    send_beat(FN_TICK, 8'd80,  4'd15, 8'h00);  // transfer starts, count saturates
    send_beat(FN_TICK, 8'd255, 4'd10, 8'h00);
    send_beat(FN_TICK, 8'd255, 4'd0,  8'h00);
    send_beat(FN_STAT, 8'd0,   4'd0,  8'h00);
    send_beat(FN_TICK, 8'd255, 4'd3,  8'h00);
    send_beat(FN_LYC,  8'd0,   4'd0,  8'h01);
    send_beat(FN_TICK, 8'd255, 4'd11, 8'h00);
    send_beat(FN_TICK, 8'd255, 4'd8,  8'h00);
    send_beat(FN_LCDC, 8'd0,   4'd0,  8'h7F);  // switch off: mode bits and LY cleared
    send_beat(FN_TICK, 8'd255, 4'd0,  8'h00);
    send_beat(FN_STAT, 8'd0,   4'd0,  8'h55);
    send_beat(FN_LCDC, 8'd0,   4'd0,  8'h80);
    send_beat(FN_STAT, 8'd0,   4'd0,  8'h50);
    send_beat(FN_TICK, 8'd0,   4'd0,  8'h00);
    lcd_on_sent = 1'b1;

    // Random part: mostly ticks so that frames run through vblank, with
    // register writes sprinkled in and occasional display off/on.
    for (int n = 0; n < RANDOM_BEATS; n++) begin
      if (n == RANDOM_BEATS / 3) begin
        send_gap_pct = 84;
        recv_gap_pct <= 37;
      end else if (n == 2 * RANDOM_BEATS / 3) begin
        send_gap_pct = 0;
        recv_gap_pct <= 0;
        pressure_go  <= 1'b1;
      end
      pick = $urandom_range(999);
      rd   = ($urandom_range(1) != 0) ? 8'($urandom_range(255, 128)) : 8'($urandom_range(255));
      rs   = ($urandom_range(9) == 0) ? 4'($urandom_range(15, 11)) : 4'($urandom_range(10));
      rw   = 8'($urandom);
      if (pick < (lcd_on_sent ? 5 : 40)) begin
        rf = FN_LCDC;
        // off periods are kept short so most of the run has the display on
        if (lcd_on_sent) rw[LCDC_ON] = ($urandom_range(4) < 3);
        else rw[LCDC_ON] = ($urandom_range(6) != 0);
        lcd_on_sent = rw[LCDC_ON];
      end else if (pick < 100) begin
        rf = FN_STAT;
      end else if (pick < 160) begin
        rf = FN_LYC;
        if ($urandom_range(3) != 0) rw = 8'($urandom_range(153));
      end else begin
        rf = FN_TICK;
      end
      send_beat(rf, rd, rs, rw);
    end
    in_valid <= 1'b0;

    // Drain: one edge so the checker has seen the last beat, then wait
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (fail_count == 0 && pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
